@@ src/laod_pkg.sv @@
`timescale 1ns / 1ps

package laod_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SAMPLE_WINDOW_DEF = 8;
  localparam int REG_INDEX_W = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [REG_INDEX_W-1:0] reg_index_t;

  localparam reg_index_t REG_OCCUPIED_BELOW = 2'd0;
  localparam reg_index_t REG_FREE_ABOVE = 2'd1;

  localparam sample_t OCCUPIED_BELOW_RST = 12'd1000;
  localparam sample_t FREE_ABOVE_RST = 12'd2000;

  function automatic int sum_width(input int window);
    return $clog2(window * ((2 ** SAMPLE_W) - 1) + 1);
  endfunction

endpackage

@@ src/laod_cell.sv @@
`timescale 1ns / 1ps

module laod_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  laod_pkg::sample_t d,
  output laod_pkg::sample_t q
);
  import laod_pkg::*;

  sample_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= d;
    end
  end

  assign q = value;

endmodule

@@ src/laod_scale.sv @@
`timescale 1ns / 1ps

module laod_scale #(
  parameter int SAMPLE_WINDOW = laod_pkg::SAMPLE_WINDOW_DEF
) (
  input  logic                                            clk,
  input  logic                                            load,
  input  logic [laod_pkg::sum_width(SAMPLE_WINDOW)-1:0]   sum,
  output laod_pkg::sample_t                               mean
);
  import laod_pkg::*;

  // exact divide by the window: multiply by ceil(2^shift / window)
  localparam int SUM_W = sum_width(SAMPLE_WINDOW);
  localparam int LOG_W = $clog2(SAMPLE_WINDOW);
  localparam int SHIFT = SUM_W + LOG_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(SAMPLE_WINDOW) - 64'd1) / 64'(SAMPLE_WINDOW);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_C};
    end
  end

  assign mean = prod[SHIFT +: SAMPLE_W];

endmodule

@@ src/light_average_occupancy_detect.sv @@
`timescale 1ns / 1ps
// a result passes the running-sum, scale and output registers after its item is accepted
// throughput: one item per cycle, set by the running-sum update and the sample cell chain
// a stalled result holds the whole pipeline; input stall follows when all stages are full
// reset: sample cells, running sum and occupancy flag cleared (track free),
//   thresholds back to 1000 and 2000, pipeline emptied

module light_average_occupancy_detect #(
  parameter int SAMPLE_WINDOW = laod_pkg::SAMPLE_WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  laod_pkg::sample_t      light_sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output laod_pkg::sample_t      light_mean,
  output logic                   occupied,
  input  logic                   reg_write,
  input  laod_pkg::reg_index_t   reg_index,
  input  laod_pkg::sample_t      reg_data
);
  import laod_pkg::*;

  localparam int SUM_W = sum_width(SAMPLE_WINDOW);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(SAMPLE_WINDOW * ((2 ** SAMPLE_W) - 1));

  sample_t occupied_below;
  sample_t free_above;

  logic             sum_valid;
  logic             scale_valid;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  sample_t          mean;
  logic             occupied_next;

  logic accept;
  logic load_out;
  logic load_scale;

  sample_t cell_q [SAMPLE_WINDOW];

  // pipeline control
  assign load_out     = scale_valid && (!result_valid || !result_stall);
  assign load_scale   = sum_valid && (!scale_valid || load_out);
  assign sample_stall = sum_valid && !load_scale;
  assign accept       = sample_valid && !sample_stall;

  // sample chain, oldest sample at the far end
  for (genvar i = 0; i < SAMPLE_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      laod_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .d     (light_sample),
        .q     (cell_q[i])
      );
    end else begin : g_next
      laod_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  assign running_sum_next = running_sum - SUM_W'(cell_q[SAMPLE_WINDOW-1])
                          + SUM_W'(light_sample);

  laod_scale #(
    .SAMPLE_WINDOW (SAMPLE_WINDOW)
  ) u_scale (
    .clk  (clk),
    .load (load_scale),
    .sum  (running_sum),
    .mean (mean)
  );

  always_comb begin
    if (mean < occupied_below) begin
      occupied_next = 1'b1;
    end else if (mean > free_above) begin
      occupied_next = 1'b0;
    end else begin
      occupied_next = occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_below <= OCCUPIED_BELOW_RST;
      free_above     <= FREE_ABOVE_RST;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_OCCUPIED_BELOW: occupied_below <= reg_data;
        REG_FREE_ABOVE:     free_above <= reg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      sum_valid    <= 1'b0;
      scale_valid  <= 1'b0;
      result_valid <= 1'b0;
      occupied     <= 1'b0;
    end else begin
      if (accept) begin
        running_sum <= running_sum_next;
        sum_valid   <= 1'b1;
      end else if (load_scale) begin
        sum_valid <= 1'b0;
      end
      if (load_scale) begin
        scale_valid <= 1'b1;
      end else if (load_out) begin
        scale_valid <= 1'b0;
      end
      if (load_out) begin
        result_valid <= 1'b1;
        occupied     <= occupied_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      light_mean <= mean;
    end
  end

`ifndef NO_ASSERTIONS
  a_flag_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    !load_out |=> $stable(occupied))
    else $error("occupancy flag changed without a new result");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (sum_valid && scale_valid && result_valid))
    else $error("input stalled while the pipeline has room");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    running_sum <= SUM_MAX)
    else $error("running sum exceeds a full window of maximum samples");
`endif

endmodule

@@ tb/light_occupancy_checker.sv @@
`timescale 1ns / 1ps

module light_occupancy_checker #(
  parameter int WINDOW = laod_pkg::SAMPLE_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_stall,
  input  laod_pkg::sample_t    light_sample,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  laod_pkg::sample_t    light_mean,
  input  logic                 occupied,
  input  logic                 reg_write,
  input  laod_pkg::reg_index_t reg_index,
  input  laod_pkg::sample_t    reg_data,
  output int                   mismatches,
  output int                   results_open
);
  import laod_pkg::*;

  typedef struct packed {
    sample_t mean;
    logic    occupied;
  } light_result_t;

  light_result_t results_due[$];

  sample_t     window_ring [WINDOW];
  int unsigned ring_pos;
  logic [31:0] window_sum;
  logic        held_occupied;
  sample_t     occupied_below;
  sample_t     free_above;
  int          bad_count = 0;

  // one window update and hysteresis decision per accepted item
  function automatic light_result_t window_mean_step(input sample_t s);
    light_result_t r;
    logic [31:0]   mean;
    window_sum = window_sum - window_ring[ring_pos] + s;
    window_ring[ring_pos] = s;
    ring_pos = (ring_pos + 1) % WINDOW;
    mean = window_sum / WINDOW;
    if (mean < occupied_below) begin
      held_occupied = 1'b1;
    end else if (mean > free_above) begin
      held_occupied = 1'b0;
    end
    r.mean = mean[SAMPLE_W-1:0];
    r.occupied = held_occupied;
    return r;
  endfunction

  always @(posedge clk) begin
    light_result_t want;
    int            i;
    if (rst) begin
      for (i = 0; i < WINDOW; i++) begin
        window_ring[i] = '0;
      end
      ring_pos = 0;
      window_sum = '0;
      held_occupied = 1'b0;
      occupied_below = OCCUPIED_BELOW_RST;
      free_above = FREE_ABOVE_RST;
      results_due.delete();
    end else begin
      if (reg_write) begin
        case (reg_index)
          REG_OCCUPIED_BELOW: occupied_below = reg_data;
          REG_FREE_ABOVE: free_above = reg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        results_due.push_back(window_mean_step(light_sample));
      end
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          if (bad_count < 10) begin
            $display("%0t: unexpected item: light_mean %0d occupied %0b",
                     $time, light_mean, occupied);
          end
          bad_count++;
        end else begin
          want = results_due.pop_front();
          if (want.mean !== light_mean || want.occupied !== occupied) begin
            if (bad_count < 10) begin
              $display("%0t: light_mean exp %0d got %0d, occupied exp %0b got %0b",
                       $time, want.mean, light_mean, want.occupied, occupied);
            end
            bad_count++;
          end
        end
      end
    end
    results_open <= results_due.size();
    mismatches <= bad_count;
  end

endmodule

@@ tb/tb_light_average_occupancy_detect.sv @@
`timescale 1ns / 1ps

module tb_light_average_occupancy_detect;
  import laod_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES = 8;
  localparam reg_index_t REG_SPARE_2 = 2'd2;
  localparam reg_index_t REG_SPARE_3 = 2'd3;

  logic       clk;
  logic       rst;
  logic       sample_valid;
  logic       sample_stall;
  sample_t    light_sample;
  logic       result_valid;
  logic       result_stall;
  sample_t    light_mean;
  logic       occupied;
  logic       reg_write;
  reg_index_t reg_index;
  sample_t    reg_data;

  int mismatches;
  int results_open;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int light_level = 2000;

  light_average_occupancy_detect uut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .light_sample  (light_sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .light_mean    (light_mean),
    .occupied      (occupied),
    .reg_write     (reg_write),
    .reg_index     (reg_index),
    .reg_data      (reg_data)
  );

  light_occupancy_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .light_sample  (light_sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .light_mean    (light_mean),
    .occupied      (occupied),
    .reg_write     (reg_write),
    .reg_index     (reg_index),
    .reg_data      (reg_data),
    .mismatches    (mismatches),
    .results_open  (results_open)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_light(input sample_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      light_sample <= sample_t'($urandom);
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    light_sample <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input sample_t value);
    reg_write <= 1'b1;
    reg_index <= idx;
    reg_data <= value;
    @(posedge clk);
  endtask

  // all results in and pipeline empty
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (results_open != 0);
    repeat (5) @(posedge clk);
  endtask

  // drifting light level with noise, plus jumps, full-range and extreme samples
  function automatic sample_t next_light();
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 5) begin
      light_level = $urandom_range(4095);
    end
    if (pick < 15) begin
      return sample_t'($urandom);
    end else if (pick < 25) begin
      return ($urandom_range(1) != 0) ? sample_t'(4095) : sample_t'(0);
    end
    light_level += $urandom_range(600) - 300;
    if (light_level < 0) light_level = 0;
    if (light_level > 4095) light_level = 4095;
    value = light_level + $urandom_range(400) - 200;
    if (value < 0) value = 0;
    if (value > 4095) value = 4095;
    return sample_t'(value);
  endfunction

  int      phase;
  int      n;
  sample_t occupied_tab [PHASES] = '{12'd1000, 12'd0, 12'd4095, 12'd3000,
                                     12'd500, 12'd2048, 12'd1200, 12'd4095};
  sample_t free_tab [PHASES] = '{12'd2000, 12'd4095, 12'd0, 12'd1500,
                                 12'd3500, 12'd2048, 12'd1300, 12'd4095};
  int      idle_tab [4] = '{0, 62, 0, 27};
  int      stall_tab [4] = '{0, 0, 62, 27};

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    light_sample <= '0;
    reg_write <= 1'b0;
    reg_index <= REG_OCCUPIED_BELOW;
    reg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full scale up, into the band, dark, back into the band
    write_reg(REG_OCCUPIED_BELOW, 12'd1000);
    write_reg(REG_FREE_ABOVE, 12'd2000);
    write_reg(REG_SPARE_2, sample_t'($urandom));
    write_reg(REG_SPARE_3, sample_t'($urandom));
    reg_write <= 1'b0;
    @(posedge clk);
    repeat (8) send_light(12'd4095);
    repeat (6) send_light(12'd1500);
    repeat (8) send_light(12'd0);
    repeat (3) send_light(12'd1500);
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_OCCUPIED_BELOW, occupied_tab[phase]);
      write_reg(REG_FREE_ABOVE, free_tab[phase]);
      if (phase % 3 == 0) begin
        write_reg((phase % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3, sample_t'($urandom));
      end
      reg_write <= 1'b0;
      @(posedge clk);
      send_idle_pct = idle_tab[phase % 4];
      recv_stall_pct = stall_tab[phase % 4];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_light(next_light());
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
